/* rtl/core/kdpc_pkg.sv */
// Shared constants, types and key map for the key debounce and press classifier.
// No dependencies; every module of the block refers to this package by scoped names.
`default_nettype none

package kdpc_pkg;

  localparam int NUM_KEYS       = 6;
  localparam int DEBOUNCE_LIMIT = 4;
  localparam int INV_KEYS       = 6;

  localparam int PORT_W  = 16;
  localparam int HP_W    = 16;
  localparam int LC_W    = 8;
  localparam int SEQ_W   = 32;
  localparam int KEY_W   = 3;
  localparam int KIND_W  = 3;
  localparam int INT_W   = $clog2(DEBOUNCE_LIMIT + 1);
  localparam int SLOTS   = 2 * NUM_KEYS;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(NUM_KEYS + 1);
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [INT_W-1:0] INT_MAX  = INT_W'(DEBOUNCE_LIMIT);
  localparam logic [INT_W-1:0] INT_INIT = INT_W'(DEBOUNCE_LIMIT / 2);

  localparam logic [HP_W-1:0] HOLD_PERIOD_RST = HP_W'(500);
  localparam logic [LC_W-1:0] LONG_COUNT_RST  = LC_W'(5);
  localparam logic [LC_W-1:0] PERIODS_MAX     = '1;

  localparam logic [3:0] PORT_BIT [16] = '{
    4'd7, 4'd3, 4'd5, 4'd4, 4'd6, 4'd2, 4'd0, 4'd1,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
  };

  typedef enum logic [KIND_W-1:0] {
    EV_PRESS   = 3'd0,
    EV_RELEASE = 3'd1,
    EV_SHORT   = 3'd2,
    EV_LONG    = 3'd3,
    EV_REPEAT  = 3'd4
  } ev_kind_e;

  typedef enum logic [1:0] {
    REG_INVERT = 2'd0,
    REG_HOLD   = 2'd1,
    REG_LONG   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic             ev0_valid;
    ev_kind_e         ev0_kind;
    logic             ev1_valid;
    logic [SEQ_W-1:0] seq;
  } lane_ev_t;

endpackage

`default_nettype wire

/* rtl/core/kdpc_lane.sv */
// One key lane: integrating debounce, stable state, hold tick and period counters.
// Depends on kdpc_pkg; reports this tick's events to the merge stage as a lane_ev_t.
`default_nettype none

module kdpc_lane (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        tick_i,
  input  wire logic                        level_i,
  input  wire logic [kdpc_pkg::SEQ_W-1:0]  press_seq_i,
  input  wire logic [kdpc_pkg::HP_W-1:0]   hold_period_i,
  input  wire logic [kdpc_pkg::LC_W-1:0]   long_count_i,
  output logic                             press_o,
  output kdpc_pkg::lane_ev_t               ev_o
);

  logic                         stable_q, stable_d;
  logic [kdpc_pkg::INT_W-1:0]   integ_q, integ_d;
  logic [kdpc_pkg::HP_W-1:0]    ticks_q, ticks_d;
  logic [kdpc_pkg::LC_W-1:0]    periods_q, periods_d;
  logic [kdpc_pkg::SEQ_W-1:0]   seq_q, seq_d;

  logic                         settled, change, press, lift, hold, period_end;
  logic [kdpc_pkg::HP_W-1:0]    tick_next;
  logic [kdpc_pkg::LC_W-1:0]    periods_inc;

  always_comb begin
    integ_d = integ_q;
    if (level_i) begin
      if (integ_q < kdpc_pkg::INT_MAX) integ_d = integ_q + 1'b1;
    end else begin
      if (integ_q != '0) integ_d = integ_q - 1'b1;
    end
  end

  assign settled     = (integ_d == '0) || (integ_d == kdpc_pkg::INT_MAX);
  assign change      = settled && (stable_q != level_i);
  assign press       = change && level_i;
  assign lift        = change && !level_i;
  assign hold        = settled && !change && stable_q;
  assign tick_next   = ticks_q + 1'b1;
  assign period_end  = hold && (tick_next == hold_period_i);
  assign periods_inc = (periods_q == kdpc_pkg::PERIODS_MAX) ? periods_q : periods_q + 1'b1;

  assign press_o = press;

  always_comb begin
    ev_o.ev0_valid = 1'b0;
    ev_o.ev0_kind  = kdpc_pkg::EV_PRESS;
    if (press) begin
      ev_o.ev0_valid = 1'b1;
    end else if (lift && (periods_q < long_count_i)) begin
      ev_o.ev0_valid = 1'b1;
      ev_o.ev0_kind  = kdpc_pkg::EV_SHORT;
    end else if (period_end && (periods_q >= long_count_i)) begin
      ev_o.ev0_valid = 1'b1;
      ev_o.ev0_kind  = kdpc_pkg::EV_REPEAT;
    end else if (period_end && (periods_inc == long_count_i)) begin
      ev_o.ev0_valid = 1'b1;
      ev_o.ev0_kind  = kdpc_pkg::EV_LONG;
    end
    ev_o.ev1_valid = lift;
    ev_o.seq       = press ? press_seq_i : seq_q;
  end

  always_comb begin
    stable_d  = stable_q;
    ticks_d   = ticks_q;
    periods_d = periods_q;
    seq_d     = seq_q;
    if (change) begin
      stable_d  = level_i;
      ticks_d   = '0;
      periods_d = '0;
      if (press) seq_d = press_seq_i;
    end else if (hold) begin
      if (period_end) begin
        ticks_d   = '0;
        periods_d = periods_inc;
      end else begin
        ticks_d = tick_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q  <= 1'b0;
      integ_q   <= kdpc_pkg::INT_INIT;
      ticks_q   <= '0;
      periods_q <= '0;
      seq_q     <= '0;
    end else if (tick_i) begin
      stable_q  <= stable_d;
      integ_q   <= integ_d;
      ticks_q   <= ticks_d;
      periods_q <= periods_d;
      seq_q     <= seq_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/kdpc_merge.sv */
// Merge stage: latches the events of all lanes for one tick and sends them out in key order.
// Depends on kdpc_pkg; drives the output register of the result channel.
`default_nettype none

module kdpc_merge (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          load_i,
  input  wire kdpc_pkg::lane_ev_t            ev_i [kdpc_pkg::NUM_KEYS],
  output logic                               busy_o,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic [kdpc_pkg::KEY_W-1:0]         key_index_o,
  output logic [kdpc_pkg::KIND_W-1:0]        event_kind_o,
  output logic [kdpc_pkg::SEQ_W-1:0]         sequence_number_o,
  output logic                               last_of_tick_o
);

  logic [kdpc_pkg::SLOTS-1:0]    pend_q, pend_d, pend_new, sel_hot;
  kdpc_pkg::ev_kind_e            kind_q [kdpc_pkg::NUM_KEYS];
  logic [kdpc_pkg::SEQ_W-1:0]    seq_q  [kdpc_pkg::NUM_KEYS];
  logic [kdpc_pkg::SLOT_W-1:0]   sel;
  logic                          take, drain;

  logic                          out_valid_q;
  logic [kdpc_pkg::KEY_W-1:0]    key_q;
  logic [kdpc_pkg::KIND_W-1:0]   kind_out_q;
  logic [kdpc_pkg::SEQ_W-1:0]    seq_out_q;
  logic                          last_q;

  always_comb begin
    for (int k = 0; k < kdpc_pkg::NUM_KEYS; k++) begin
      pend_new[2*k]   = ev_i[k].ev0_valid;
      pend_new[2*k+1] = ev_i[k].ev1_valid;
    end
  end

  always_comb begin
    sel = '0;
    for (int j = kdpc_pkg::SLOTS - 1; j >= 0; j--) begin
      if (pend_q[j]) sel = kdpc_pkg::SLOT_W'(j);
    end
  end

  assign sel_hot = kdpc_pkg::SLOTS'(1) << sel;
  assign take    = !out_valid_q || !out_stall_i;
  assign drain   = take && (pend_q != '0);
  assign busy_o  = (pend_q != '0);

  always_comb begin
    pend_d = pend_q;
    if (load_i) pend_d = pend_new;
    else if (drain) pend_d = pend_q & ~sel_hot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (take) out_valid_q <= drain;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int k = 0; k < kdpc_pkg::NUM_KEYS; k++) begin
        kind_q[k] <= ev_i[k].ev0_kind;
        seq_q[k]  <= ev_i[k].seq;
      end
    end
    if (drain) begin
      key_q      <= kdpc_pkg::KEY_W'(sel >> 1);
      kind_out_q <= sel[0] ? kdpc_pkg::EV_RELEASE : kind_q[sel[kdpc_pkg::SLOT_W-1:1]];
      seq_out_q  <= seq_q[sel[kdpc_pkg::SLOT_W-1:1]];
      last_q     <= ((pend_q & ~sel_hot) == '0);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign key_index_o       = key_q;
  assign event_kind_o      = kind_out_q;
  assign sequence_number_o = seq_out_q;
  assign last_of_tick_o    = last_q;

  a_load_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (pend_q == '0))
    else $error("tick loaded while events still pending");

  a_no_new_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load_i |=> ((pend_q & ~$past(pend_q)) == '0))
    else $error("pending slot appeared without a load");

  a_last_marks_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain && (pend_d == '0)) |=> (out_valid_o && last_of_tick_o))
    else $error("final word of a tick not marked last");

  a_drain_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain |=> ($countones(pend_q) == $countones($past(pend_q)) - 1))
    else $error("drain did not retire exactly one slot");

endmodule

`default_nettype wire

/* rtl/core/key_debounce_press_classifier_top.sv */
// Top level of the key debounce and press classifier: config registers, port hold, lanes.
// Depends on kdpc_pkg, kdpc_lane and kdpc_merge.
`default_nettype none

// Channel  | handshake                   | payload
// in       | in_valid_i / in_stall_o     | port_bits_i, read_ok_i
// out      | out_valid_o / out_stall_i   | key_index_o, event_kind_o, sequence_number_o,
//          |                             | last_of_tick_o
// config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// All key lanes update in the cycle a tick is accepted; the merge stage then sends one
// word per cycle while the output is not stalled; a tick with events carries 1 to 12 words.
// A new tick is taken in the cycle after the previous tick's last word has entered the
// output register; a tick without events leaves the block ready in the next cycle.
// Reset is asynchronous: lanes released with integrators at the midpoint, no clearing pass.
// A stall on the output holds the output register and, while words are pending, the input.

module key_debounce_press_classifier_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [kdpc_pkg::PORT_W-1:0]       port_bits_i,
  input  wire logic                              read_ok_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [kdpc_pkg::KEY_W-1:0]             key_index_o,
  output logic [kdpc_pkg::KIND_W-1:0]            event_kind_o,
  output logic [kdpc_pkg::SEQ_W-1:0]             sequence_number_o,
  output logic                                   last_of_tick_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [kdpc_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [kdpc_pkg::DATA_W-1:0]       pwdata,
  output logic [kdpc_pkg::DATA_W-1:0]            prdata,
  output logic                                   pready
);

  logic [kdpc_pkg::INV_KEYS-1:0]  invert_q;
  logic [kdpc_pkg::HP_W-1:0]      hold_period_q;
  logic [kdpc_pkg::LC_W-1:0]      long_count_q;
  logic [kdpc_pkg::PORT_W-1:0]    held_q, held_d;
  logic [kdpc_pkg::SEQ_W-1:0]     next_seq_q, next_seq_d;

  logic                           accept, cfg_we, busy;
  kdpc_pkg::reg_idx_e             reg_idx;
  logic [kdpc_pkg::NUM_KEYS-1:0]  level, press;
  logic [kdpc_pkg::CNT_W-1:0]     prefix [kdpc_pkg::NUM_KEYS+1];
  logic [kdpc_pkg::SEQ_W-1:0]     press_seq [kdpc_pkg::NUM_KEYS];
  kdpc_pkg::lane_ev_t             lane_ev [kdpc_pkg::NUM_KEYS];

  assign pready     = 1'b1;
  assign cfg_we     = psel && penable && pwrite && pready;
  assign reg_idx    = kdpc_pkg::reg_idx_e'(paddr[3:2]);
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign held_d     = read_ok_i ? port_bits_i : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q      <= '0;
      hold_period_q <= kdpc_pkg::HOLD_PERIOD_RST;
      long_count_q  <= kdpc_pkg::LONG_COUNT_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        kdpc_pkg::REG_INVERT: invert_q      <= pwdata[kdpc_pkg::INV_KEYS-1:0];
        kdpc_pkg::REG_HOLD:   hold_period_q <= pwdata[kdpc_pkg::HP_W-1:0];
        kdpc_pkg::REG_LONG:   long_count_q  <= pwdata[kdpc_pkg::LC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      kdpc_pkg::REG_INVERT: prdata = kdpc_pkg::DATA_W'(invert_q);
      kdpc_pkg::REG_HOLD:   prdata = kdpc_pkg::DATA_W'(hold_period_q);
      kdpc_pkg::REG_LONG:   prdata = kdpc_pkg::DATA_W'(long_count_q);
      default:              prdata = '0;
    endcase
  end

  always_comb begin
    prefix[0] = '0;
    for (int k = 0; k < kdpc_pkg::NUM_KEYS; k++) begin
      prefix[k+1]  = prefix[k] + kdpc_pkg::CNT_W'(press[k]);
      press_seq[k] = next_seq_q + kdpc_pkg::SEQ_W'(prefix[k]);
    end
  end

  assign next_seq_d = next_seq_q + kdpc_pkg::SEQ_W'(prefix[kdpc_pkg::NUM_KEYS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= '0;
      next_seq_q <= kdpc_pkg::SEQ_W'(1);
    end else if (accept) begin
      held_q     <= held_d;
      next_seq_q <= next_seq_d;
    end
  end

  for (genvar k = 0; k < kdpc_pkg::NUM_KEYS; k++) begin : g_lane
    if (k < kdpc_pkg::INV_KEYS) begin : g_inv
      assign level[k] = held_d[kdpc_pkg::PORT_BIT[k]] ^ invert_q[k];
    end else begin : g_plain
      assign level[k] = held_d[kdpc_pkg::PORT_BIT[k]];
    end

    kdpc_lane u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .tick_i        (accept),
      .level_i       (level[k]),
      .press_seq_i   (press_seq[k]),
      .hold_period_i (hold_period_q),
      .long_count_i  (long_count_q),
      .press_o       (press[k]),
      .ev_o          (lane_ev[k])
    );
  end

  kdpc_merge u_merge (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (accept),
    .ev_i              (lane_ev),
    .busy_o            (busy),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .key_index_o       (key_index_o),
    .event_kind_o      (event_kind_o),
    .sequence_number_o (sequence_number_o),
    .last_of_tick_o    (last_of_tick_o)
  );

  a_seq_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> (next_seq_q == $past(next_seq_q)))
    else $error("sequence counter moved without a tick");

  a_held_on_fail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !read_ok_i) |=> (held_q == $past(held_q)))
    else $error("held port changed on a failed read");

  a_press_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (next_seq_q == $past(next_seq_q) + kdpc_pkg::SEQ_W'($countones($past(press)))))
    else $error("sequence counter does not match press count");

endmodule

`default_nettype wire

/* tb/tb_key_debounce_press_classifier_top.sv */
`timescale 1ns / 100ps
// Testbench for key_debounce_press_classifier_top: ticks in, key event words out.
// Predicts each event word in a scoreboard class and checks the output in order.
// Depends on kdpc_pkg and the block's RTL.

module tb_key_debounce_press_classifier_top;

  localparam int KEYS = 6;
  localparam logic [2:0] INT_FULL = 3'd4;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE = 16;
  localparam int GAP_MAX = 8;
  localparam logic [3:0] KEY_BIT [KEYS] = '{4'd7, 4'd3, 4'd5, 4'd4, 4'd6, 4'd2};

  typedef struct packed {
    logic [kdpc_pkg::KEY_W-1:0] key;
    kdpc_pkg::ev_kind_e         kind;
    logic [kdpc_pkg::SEQ_W-1:0] seq;
    logic                       last;
  } key_event_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [kdpc_pkg::PORT_W-1:0]   port_bits_i = '0;
  logic                          read_ok_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [kdpc_pkg::KEY_W-1:0]    key_index_o;
  logic [kdpc_pkg::KIND_W-1:0]   event_kind_o;
  logic [kdpc_pkg::SEQ_W-1:0]    sequence_number_o;
  logic                          last_of_tick_o;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [kdpc_pkg::ADDR_W-1:0]   paddr = '0;
  logic [kdpc_pkg::DATA_W-1:0]   pwdata = '0;
  logic [kdpc_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  int send_idle_pct = 19;
  int stall_pct = 71;
  int burst_asked = 0;

  class key_event_board;
    logic [5:0]  inv_mask;
    logic [15:0] period;
    logic [7:0]  long_at;
    logic [15:0] port_q;
    logic        pressed [KEYS];
    logic [2:0]  integ [KEYS];
    logic [15:0] ticks [KEYS];
    logic [7:0]  periods [KEYS];
    logic [31:0] press_seq [KEYS];
    logic [31:0] seq_next;
    key_event_t  pending_events [$];
    int          errors;

    function new();
      inv_mask = 6'h00;
      period = 16'd500;
      long_at = 8'd5;
      port_q = 16'h0000;
      for (int k = 0; k < KEYS; k++) begin
        pressed[k] = 1'b0;
        integ[k] = 3'd2;
        ticks[k] = 16'd0;
        periods[k] = 8'd0;
        press_seq[k] = 32'd0;
      end
      seq_next = 32'd1;
      errors = 0;
    endfunction

    function void set_reg(kdpc_pkg::reg_idx_e idx, logic [31:0] value);
      case (idx)
        kdpc_pkg::REG_INVERT: inv_mask = value[5:0];
        kdpc_pkg::REG_HOLD:   period = value[15:0];
        kdpc_pkg::REG_LONG:   long_at = value[7:0];
        default: ;
      endcase
    endfunction

    function key_event_t event_of(int k, kdpc_pkg::ev_kind_e kind);
      key_event_t e;
      e.key = kdpc_pkg::KEY_W'(k);
      e.kind = kind;
      e.seq = press_seq[k];
      e.last = 1'b0;
      return e;
    endfunction

    function void take_tick(logic [15:0] bits, logic ok);
      key_event_t  made [$];
      logic        level;
      logic [15:0] t;
      logic [7:0]  old;
      int          k;
      if (ok)
        port_q = bits;
      for (k = 0; k < KEYS; k++) begin
        level = port_q[KEY_BIT[k]] ^ inv_mask[k];
        if (level) begin
          if (integ[k] < INT_FULL)
            integ[k] = integ[k] + 3'd1;
        end else if (integ[k] > 3'd0) begin
          integ[k] = integ[k] - 3'd1;
        end
        if (integ[k] != 3'd0 && integ[k] != INT_FULL)
          continue;
        if (pressed[k] != level) begin
          pressed[k] = level;
          if (level) begin
            press_seq[k] = seq_next;
            seq_next = seq_next + 32'd1;
            ticks[k] = 16'd0;
            periods[k] = 8'd0;
            made.push_back(event_of(k, kdpc_pkg::EV_PRESS));
          end else begin
            if (periods[k] < long_at)
              made.push_back(event_of(k, kdpc_pkg::EV_SHORT));
            periods[k] = 8'd0;
            ticks[k] = 16'd0;
            made.push_back(event_of(k, kdpc_pkg::EV_RELEASE));
          end
        end else if (pressed[k]) begin
          t = ticks[k] + 16'd1;
          if (t == period) begin
            old = periods[k];
            ticks[k] = 16'd0;
            if (old != 8'hFF)
              periods[k] = old + 8'd1;
            if (old >= long_at)
              made.push_back(event_of(k, kdpc_pkg::EV_REPEAT));
            else if (periods[k] == long_at)
              made.push_back(event_of(k, kdpc_pkg::EV_LONG));
          end else begin
            ticks[k] = t;
          end
        end
      end
      if (made.size() > 0)
        made[made.size() - 1].last = 1'b1;
      foreach (made[i])
        pending_events.push_back(made[i]);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40)
        $display("%0t key event check: %s", $time, what);
    endtask

    task check_event(logic [kdpc_pkg::KEY_W-1:0] key, logic [kdpc_pkg::KIND_W-1:0] kind,
                     logic [kdpc_pkg::SEQ_W-1:0] seq, logic last);
      key_event_t want;
      if (pending_events.size() == 0) begin
        report($sformatf("unexpected word key %0d kind %0d seq %0d last %0b",
                         key, kind, seq, last));
        return;
      end
      want = pending_events.pop_front();
      if (key !== want.key || kind !== want.kind || seq !== want.seq || last !== want.last)
        report($sformatf(
          "got key %0d kind %0d seq %0d last %0b, want key %0d kind %0d seq %0d last %0b",
          key, kind, seq, last, want.key, want.kind, want.seq, want.last));
    endtask
  endclass

  key_event_board board = new();

  key_debounce_press_classifier_top dut (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_event(key_index_o, event_kind_o, sequence_number_o, last_of_tick_o);
  end

  initial begin : receiver
    int left;
    int seen;
    left = 0;
    seen = 0;
    forever begin
      @(negedge clk_i);
      if (burst_asked != seen) begin
        seen = burst_asked;
        left = LONG_HOLD;
      end
      if (left > 0) begin
        left--;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("key_debounce_press_classifier_top: mismatch");
    $finish;
  end

  task automatic send_tick(input logic [15:0] bits, input logic ok);
    int gap;
    gap = 0;
    while (gap < GAP_MAX && $urandom_range(99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    port_bits_i = bits;
    read_ok_i = ok;
    do @(posedge clk_i); while (in_stall_o);
    board.take_tick(bits, ok);
    @(negedge clk_i);
  endtask

  task automatic send_run(input logic [15:0] bits, input logic ok, input int count);
    repeat (count) send_tick(bits, ok);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (board.pending_events.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input kdpc_pkg::reg_idx_e idx, input logic [31:0] value);
    logic [31:0] kept;
    case (idx)
      kdpc_pkg::REG_INVERT: kept = value & 32'h0000_003F;
      kdpc_pkg::REG_HOLD:   kept = value & 32'h0000_FFFF;
      default:              kept = value & 32'h0000_00FF;
    endcase
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_reg(idx, value);
    @(negedge clk_i);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== kept)
      board.report($sformatf("register %0d reads %0h, want %0h", idx, prdata, kept));
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_config(input logic [5:0] mask, input logic [15:0] hp, input logic [7:0] lc);
    write_reg(kdpc_pkg::REG_INVERT, {26'd0, mask});
    write_reg(kdpc_pkg::REG_HOLD, {16'd0, hp});
    write_reg(kdpc_pkg::REG_LONG, {24'd0, lc});
  endtask

  initial begin : stimulus
    logic [15:0] target;
    logic [15:0] bits;
    logic        ok;
    int          seg;
    int          n;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    set_config(6'h00, 16'd2, 8'd2);
    send_run(16'hFFFF, 1'b1, 6);
    send_run(16'h0000, 1'b0, 2);
    send_run(16'h0000, 1'b1, 4);
    send_run(16'hFFFF, 1'b1, 1);
    send_run(16'h0000, 1'b1, 1);
    send_run(16'hFFFF, 1'b1, 1);
    send_run(16'h0000, 1'b1, 1);
    send_run(16'hFFFF, 1'b1, 4);
    send_run(16'h0000, 1'b1, 4);

    // long count zero: repeat on every period, no short on release
    wait_drained();
    set_config(6'h3F, 16'd1, 8'd0);
    send_run(16'h0000, 1'b1, 7);
    send_run(16'hFFFF, 1'b1, 4);

    target = 16'h0000;
    for (seg = 0; seg < 6; seg++) begin
      wait_drained();
      if (seg == 2) begin
        send_idle_pct = 71;
        stall_pct <= 19;
      end
      if (seg == 4) begin
        send_idle_pct = 0;
        stall_pct <= 0;
      end
      case (seg)
        0: set_config(6'h3F, 16'd1, 8'd1);
        1: set_config(6'($urandom), 16'($urandom_range(5, 2)), 8'($urandom_range(3, 1)));
        2: set_config(6'h00, 16'hFFFF, 8'hFF);
        3: set_config(6'($urandom), 16'd1, 8'd0);
        4: set_config(6'($urandom), 16'($urandom_range(8, 1)), 8'($urandom_range(4, 1)));
        default: set_config(6'($urandom), 16'($urandom_range(3, 1)), 8'($urandom_range(2, 0)));
      endcase
      for (n = 0; n < 40; n++) begin
        if (seg == 0 && n == 10)
          burst_asked <= burst_asked + 1;
        if (seg == 1 && n == 25)
          wait_drained();
        if ($urandom_range(7) == 0)
          target = target ^ (16'($urandom) & 16'($urandom));
        bits = target;
        if ($urandom_range(5) == 0)
          bits = bits ^ (16'd1 << $urandom_range(15));
        ok = ($urandom_range(9) != 0);
        if (!ok)
          bits = 16'($urandom);
        send_tick(bits, ok);
      end
    end

    wait_drained();
    if (board.errors == 0)
      $display("key_debounce_press_classifier_top: match");
    else
      $display("key_debounce_press_classifier_top: mismatch");
    $finish;
  end

endmodule
